/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/wcp_pkg.sv */
// ----------------------------------------------------------------------------
// WAV chunk header parser package
// Status codes, chunk tags, header marks and the result record.
// ----------------------------------------------------------------------------
package wcp_pkg;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_CHUNK   = 2'd2;

    localparam logic [31:0] RIFF_MARK = 32'h5249_4646;
    localparam logic [31:0] WAVE_MARK = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT   = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA  = 32'h6461_7461;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
        logic [31:0] data_offset;
    } result_t;

    function automatic logic [7:0] mark_byte(input logic [31:0] mark, input logic [1:0] idx);
        logic [31:0] shifted;
        shifted = mark >> {~idx, 3'b000};
        return shifted[7:0];
    endfunction

endpackage

/* hw/rtl/wcp_parse.sv */
// ----------------------------------------------------------------------------
// WAV chunk header parser core
// Holds the parse state and works out the effect of each byte combinationally.
// ----------------------------------------------------------------------------
module wcp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output wcp_pkg::result_t  res
);

    logic [31:0] byte_offset_reg, byte_offset_next;
    logic [31:0] chunk_tag_reg, chunk_tag_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [4:0]  chunk_position_reg, chunk_position_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] format_code_reg, format_code_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] rate_value_reg, rate_value_next;
    logic [15:0] sample_bits_reg, sample_bits_next;
    logic        result_given_reg, result_given_next;

    logic [31:0] offset_inc;
    logic [31:0] length_merged;
    logic [31:0] length_dec;
    logic [3:0]  body_idx;
    logic        give;
    logic [1:0]  give_status;

    assign offset_inc    = (byte_offset_reg == 32'hFFFF_FFFF) ? byte_offset_reg
                                                               : byte_offset_reg + 32'd1;
    assign length_merged = chunk_length_reg
                         | ({24'd0, data_byte} << {chunk_position_reg[1:0], 3'b000});
    assign length_dec    = chunk_length_reg - 32'd1;
    assign body_idx      = chunk_position_reg[3:0] - 4'd8;

    always_comb
    begin
        byte_offset_next    = offset_inc;
        chunk_tag_next      = chunk_tag_reg;
        chunk_length_next   = chunk_length_reg;
        chunk_position_next = chunk_position_reg;
        fmt_seen_next       = fmt_seen_reg;
        format_code_next    = format_code_reg;
        channel_count_next  = channel_count_reg;
        rate_value_next     = rate_value_reg;
        sample_bits_next    = sample_bits_reg;
        result_given_next   = result_given_reg;
        give                = 1'b0;
        give_status         = wcp_pkg::ST_OK;

        if (!result_given_reg)
        begin
            if (byte_offset_reg < 32'd12)
            begin
                if (byte_offset_reg < 32'd4)
                begin
                    if (data_byte != wcp_pkg::mark_byte(wcp_pkg::RIFF_MARK,
                                                        byte_offset_reg[1:0]))
                    begin
                        give        = 1'b1;
                        give_status = wcp_pkg::ST_BAD_HEADER;
                    end
                end
                else if (byte_offset_reg >= 32'd8)
                begin
                    if (data_byte != wcp_pkg::mark_byte(wcp_pkg::WAVE_MARK,
                                                        byte_offset_reg[1:0]))
                    begin
                        give        = 1'b1;
                        give_status = wcp_pkg::ST_BAD_HEADER;
                    end
                end
            end
            else if (chunk_position_reg < 5'd4)
            begin
                chunk_tag_next      = {chunk_tag_reg[23:0], data_byte};
                chunk_position_next = chunk_position_reg + 5'd1;
            end
            else if (chunk_position_reg < 5'd8)
            begin
                chunk_length_next   = length_merged;
                chunk_position_next = chunk_position_reg + 5'd1;
                if (chunk_position_reg == 5'd7)
                begin
                    if (chunk_tag_reg == wcp_pkg::TAG_DATA)
                    begin
                        give        = 1'b1;
                        give_status = fmt_seen_reg ? wcp_pkg::ST_OK : wcp_pkg::ST_NO_CHUNK;
                    end
                    else
                    begin
                        if (chunk_tag_reg == wcp_pkg::TAG_FMT)
                        begin
                            fmt_seen_next = 1'b1;
                        end
                        if (length_merged == 32'd0)
                        begin
                            chunk_position_next = 5'd0;
                            chunk_tag_next      = 32'd0;
                        end
                    end
                end
            end
            else
            begin
                if (chunk_tag_reg == wcp_pkg::TAG_FMT && chunk_position_reg < 5'd24)
                begin
                    case (body_idx)
                        4'd0:    format_code_next[7:0]   = data_byte;
                        4'd1:    format_code_next[15:8]  = data_byte;
                        4'd2:    channel_count_next[7:0] = data_byte;
                        4'd3:    channel_count_next[15:8] = data_byte;
                        4'd4:    rate_value_next[7:0]    = data_byte;
                        4'd5:    rate_value_next[15:8]   = data_byte;
                        4'd6:    rate_value_next[23:16]  = data_byte;
                        4'd7:    rate_value_next[31:24]  = data_byte;
                        4'd14:   sample_bits_next[7:0]   = data_byte;
                        4'd15:   sample_bits_next[15:8]  = data_byte;
                        default: ;
                    endcase
                end
                chunk_length_next = length_dec;
                if (length_dec == 32'd0)
                begin
                    chunk_position_next = 5'd0;
                    chunk_tag_next      = 32'd0;
                end
                else if (chunk_position_reg != 5'd31)
                begin
                    chunk_position_next = chunk_position_reg + 5'd1;
                end
            end

            if (!give && last)
            begin
                give        = 1'b1;
                give_status = (byte_offset_reg < 32'd11) ? wcp_pkg::ST_BAD_HEADER
                                                         : wcp_pkg::ST_NO_CHUNK;
            end
        end

        if (give)
        begin
            result_given_next = 1'b1;
        end

        if (last)
        begin
            byte_offset_next    = 32'd0;
            chunk_tag_next      = 32'd0;
            chunk_length_next   = 32'd0;
            chunk_position_next = 5'd0;
            fmt_seen_next       = 1'b0;
            format_code_next    = 16'd1;
            channel_count_next  = 16'd0;
            rate_value_next     = 32'd0;
            sample_bits_next    = 16'd0;
            result_given_next   = 1'b0;
        end
    end

    always_comb
    begin
        res        = '0;
        res.valid  = give;
        res.status = give_status;
        if (give_status == wcp_pkg::ST_OK)
        begin
            res.audio_format    = format_code_reg;
            res.channels        = channel_count_reg;
            res.sample_rate     = rate_value_reg;
            res.bits_per_sample = sample_bits_reg;
            res.data_size       = length_merged;
            res.data_offset     = offset_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= 32'd0;
            chunk_tag_reg      <= 32'd0;
            chunk_length_reg   <= 32'd0;
            chunk_position_reg <= 5'd0;
            fmt_seen_reg       <= 1'b0;
            format_code_reg    <= 16'd1;
            channel_count_reg  <= 16'd0;
            rate_value_reg     <= 32'd0;
            sample_bits_reg    <= 16'd0;
            result_given_reg   <= 1'b0;
        end
        else if (step)
        begin
            byte_offset_reg    <= byte_offset_next;
            chunk_tag_reg      <= chunk_tag_next;
            chunk_length_reg   <= chunk_length_next;
            chunk_position_reg <= chunk_position_next;
            fmt_seen_reg       <= fmt_seen_next;
            format_code_reg    <= format_code_next;
            channel_count_reg  <= channel_count_next;
            rate_value_reg     <= rate_value_next;
            sample_bits_reg    <= sample_bits_next;
            result_given_reg   <= result_given_next;
        end
    end

endmodule

/* hw/rtl/wav_chunk_header_parser.sv */
// ----------------------------------------------------------------------------
// WAV chunk header parser
// The block takes one file byte per cycle, unless stalled, into an input
// register, and the parse logic behind it handles that byte; a result item
// it causes is registered in an output register. Each file gives exactly
// one result item, with the format fields and the data chunk size and offset
// when the header is good. Input is stalled only while the buffered byte
// would give a result and the output register still holds an item that the
// far side is stalling; otherwise bytes flow at one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_chunk_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] audio_format,
    output logic [15:0] channels,
    output logic [31:0] sample_rate,
    output logic [15:0] bits_per_sample,
    output logic [31:0] data_size,
    output logic [31:0] data_offset
);

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             out_valid_reg;
    wcp_pkg::result_t res;
    wcp_pkg::result_t res_reg;
    logic             advance;

    wcp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .last      (last_reg),
        .res       (res)
    );

    assign advance  = in_valid_reg && (!res.valid || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance && res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last;
        end
        if (advance && res.valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = res_reg.status;
    assign audio_format    = res_reg.audio_format;
    assign channels        = res_reg.channels;
    assign sample_rate     = res_reg.sample_rate;
    assign bits_per_sample = res_reg.bits_per_sample;
    assign data_size       = res_reg.data_size;
    assign data_offset     = res_reg.data_offset;

    `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_IMPLIES(a_error_fields_zero, clk, rst_n, out_valid && status != wcp_pkg::ST_OK, audio_format == 16'd0 && data_size == 32'd0 && data_offset == 32'd0)
    `ASSERT_IMPLIES(a_ok_offset_min, clk, rst_n, out_valid && status == wcp_pkg::ST_OK, data_offset >= 32'd28)

endmodule
